/* src/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types, constants and helpers for the LRU cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;

   localparam int KEY_PORT_BITS   = 32;
   localparam int VALUE_PORT_BITS = 32;
   localparam int COUNT_BITS      = 32;
   localparam int CAP_BITS        = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } cmd_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (&v) ? v : v + COUNT_BITS'(1);
   endfunction

endpackage

`default_nettype wire

/* src/lru_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer for the cache table: capture, search, update, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ctrl import lru_pkg::*; (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire  rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = req_valid && req_ready;
      cmd.search = (state_ff == ST_SEARCH);
      cmd.commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not raise rsp_valid");

   a_load_search: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SEARCH))
      else $error("accepted transaction not searched");

   a_search_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |=> (state_ff == ST_UPDATE))
      else $error("search not followed by update");

endmodule

`default_nettype wire

/* src/lru_dp.sv */
// ----------------------------------------------------------------------------
// lru_dp
// Entry store, parallel key compare, recency ranks, counters and result
// register of the cache table.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_dp import lru_pkg::*; #(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  cmd_type                    cmd,
   input  wire                        csr_wr_en,
   input  wire  [CAP_BITS-1:0]        csr_wr_data,
   input  wire                        req_action,
   input  wire  [KEY_PORT_BITS-1:0]   req_lookup_key,
   input  wire  [VALUE_PORT_BITS-1:0] req_write_value,
   output logic                       rsp_hit,
   output logic [VALUE_PORT_BITS-1:0] rsp_read_value,
   output logic                       rsp_evicted,
   output logic [COUNT_BITS-1:0]      rsp_hit_count,
   output logic [COUNT_BITS-1:0]      rsp_miss_count,
   output logic [COUNT_BITS-1:0]      rsp_eviction_count
);

   localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int CW = (OW > CAP_BITS) ? OW : CAP_BITS;

   // entry store
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [KEY_BITS-1:0]   key_in   [ENTRIES];
   logic [VALUE_BITS-1:0] data_ff  [ENTRIES];
   logic [VALUE_BITS-1:0] data_in  [ENTRIES];
   logic [RW-1:0]         rank_ff  [ENTRIES];
   logic [RW-1:0]         rank_in  [ENTRIES];
   logic [OW-1:0]         occ_ff, occ_in;
   logic [CAP_BITS-1:0]   capacity_ff, capacity_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in, miss_ff, miss_in, evict_ff, evict_in;

   // request
   logic                  put_ff, put_in;
   logic [KEY_BITS-1:0]   req_key_ff, req_key_in;
   logic [VALUE_BITS-1:0] req_val_ff, req_val_in;

   // search results
   logic [ENTRIES-1:0]    match_ff, match_in, victim_ff, victim_in, free_ff, free_in;
   logic                  found_ff, found_in, full_ff, full_in, cap_zero_ff, cap_zero_in;
   logic [RW-1:0]         hit_rank_ff, hit_rank_in;
   logic [VALUE_BITS-1:0] hit_data_ff, hit_data_in;

   // result register
   logic                       rsp_hit_ff, rsp_hit_in, rsp_ev_ff, rsp_ev_in;
   logic [VALUE_PORT_BITS-1:0] rsp_rd_ff, rsp_rd_in;

   logic [63:0]        key_wide, val_wide, hit_wide;
   logic [ENTRIES-1:0] free_vec, slot;
   logic [RW-1:0]      lru_rank;
   logic [CW-1:0]      cap_eff;
   logic               evict;

   // request capture
   always_comb begin
      key_wide   = 64'(req_lookup_key);
      val_wide   = 64'(req_write_value);
      put_in     = put_ff;
      req_key_in = req_key_ff;
      req_val_in = req_val_ff;
      if (cmd.load) begin
         put_in     = (req_action == ACTION_PUT);
         req_key_in = key_wide[KEY_BITS-1:0];
         req_val_in = val_wide[VALUE_BITS-1:0];
      end
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
   end

   // parallel search
   always_comb begin
      lru_rank    = RW'(occ_ff - OW'(1));
      free_vec    = ~valid_ff;
      cap_eff     = (CW'(capacity_ff) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity_ff);
      match_in    = match_ff;
      victim_in   = victim_ff;
      free_in     = free_ff;
      found_in    = found_ff;
      full_in     = full_ff;
      cap_zero_in = cap_zero_ff;
      hit_rank_in = hit_rank_ff;
      hit_data_in = hit_data_ff;
      if (cmd.search) begin
         hit_rank_in = '0;
         hit_data_in = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            match_in[i]  = valid_ff[i] && (key_ff[i] == req_key_ff);
            victim_in[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
            if (match_in[i]) begin
               hit_rank_in = hit_rank_in | rank_ff[i];
               hit_data_in = hit_data_in | data_ff[i];
            end
         end
         free_in     = free_vec & (~free_vec + ENTRIES'(1));
         found_in    = |match_in;
         full_in     = CW'(occ_ff) >= cap_eff;
         cap_zero_in = (capacity_ff == '0);
      end
   end

   // commit
   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      data_in   = data_ff;
      rank_in   = rank_ff;
      occ_in    = occ_ff;
      hits_in   = hits_ff;
      miss_in   = miss_ff;
      evict_in  = evict_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_ev_in  = rsp_ev_ff;
      rsp_rd_in  = rsp_rd_ff;
      hit_wide  = 64'(hit_data_ff);
      evict     = full_ff && (|victim_ff);
      slot      = evict ? victim_ff : free_ff;
      if (cmd.commit) begin
         rsp_hit_in = 1'b0;
         rsp_ev_in  = 1'b0;
         rsp_rd_in  = '0;
         if (!put_ff) begin
            if (found_ff) begin
               rsp_hit_in = 1'b1;
               rsp_rd_in  = hit_wide[VALUE_PORT_BITS-1:0];
               hits_in    = sat_inc(hits_ff);
            end else begin
               miss_in = sat_inc(miss_ff);
            end
         end
         if ((!put_ff || !cap_zero_ff) && found_ff) begin
            // touch: entries more recent than the hit age by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (match_ff[i]) begin
                  rank_in[i] = '0;
                  if (put_ff) data_in[i] = req_val_ff;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
         end else if (put_ff && !cap_zero_ff) begin
            if (evict) begin
               rsp_ev_in = 1'b1;
               evict_in  = sat_inc(evict_ff);
            end else if (|free_ff) begin
               occ_in = occ_ff + OW'(1);
            end
            // insert as most recent
            if (|slot) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot[i]) begin
                     valid_in[i] = 1'b1;
                     key_in[i]   = req_key_ff;
                     data_in[i]  = req_val_ff;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + RW'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         occ_ff      <= '0;
         capacity_ff <= CAP_RESET;
         hits_ff     <= '0;
         miss_ff     <= '0;
         evict_ff    <= '0;
      end else begin
         valid_ff    <= valid_in;
         occ_ff      <= occ_in;
         capacity_ff <= capacity_in;
         hits_ff     <= hits_in;
         miss_ff     <= miss_in;
         evict_ff    <= evict_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      data_ff     <= data_in;
      rank_ff     <= rank_in;
      put_ff      <= put_in;
      req_key_ff  <= req_key_in;
      req_val_ff  <= req_val_in;
      match_ff    <= match_in;
      victim_ff   <= victim_in;
      free_ff     <= free_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      cap_zero_ff <= cap_zero_in;
      hit_rank_ff <= hit_rank_in;
      hit_data_ff <= hit_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_rd_ff   <= rsp_rd_in;
   end

   assign rsp_hit            = rsp_hit_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_evicted        = rsp_ev_ff;
   assign rsp_hit_count      = hits_ff;
   assign rsp_miss_count     = miss_ff;
   assign rsp_eviction_count = evict_ff;

   // occupancy always matches the number of valid entries
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("occupancy out of step with valid entries");

   // keys are unique, so a lookup matches at most one entry
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.search) |-> $onehot0(match_ff))
      else $error("key matched more than one entry");

   a_victim_unique: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.search) |-> $onehot0(victim_ff))
      else $error("more than one least recent entry");

endmodule

`default_nettype wire

/* src/lru_cache_table.sv */
// ----------------------------------------------------------------------------
// lru_cache_table
// Fully associative key/value cache with least-recently-used replacement
// and saturating hit, miss and eviction counters.
// ----------------------------------------------------------------------------
// Each transaction is a get or a put and gives exactly one result. It is
// accepted and captured in the idle state, its key is compared against
// every entry in parallel with the victim and free slot search in the
// search state, and entries, ranks, counters and the result register are
// updated in the update state. A new transaction is taken only when the
// block is idle again; a waiting result holds back only the update step.
// Reset clears all entries by clearing their valid bits, with no clearing
// pass. The counter outputs show the totals after the transaction on the
// result port. Capacity is written through csr_wr_en and csr_wr_data while
// idle; the user must keep to this, as the block itself does not enforce it.
`default_nettype none

module lru_cache_table import lru_pkg::*; #(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire  [CAP_BITS-1:0]        csr_wr_data,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_action,
   input  wire  [KEY_PORT_BITS-1:0]   req_lookup_key,
   input  wire  [VALUE_PORT_BITS-1:0] req_write_value,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       rsp_hit,
   output logic [VALUE_PORT_BITS-1:0] rsp_read_value,
   output logic                       rsp_evicted,
   output logic [COUNT_BITS-1:0]      rsp_hit_count,
   output logic [COUNT_BITS-1:0]      rsp_miss_count,
   output logic [COUNT_BITS-1:0]      rsp_eviction_count
);

   cmd_type cmd;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lru_dp #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_action         (req_action),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .rsp_evicted        (rsp_evicted),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_eviction_count (rsp_eviction_count)
   );

endmodule

`default_nettype wire
